// ===== rtl/tabular_q_value_update_assert.svh =====
// Assertion macros for the Q value update RTL.
`ifndef TABULAR_Q_VALUE_UPDATE_ASSERT_SVH
`define TABULAR_Q_VALUE_UPDATE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define TQV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define TQV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tqv_pkg.sv =====
// Types, constants and helpers for the tabular Q value update block.
`timescale 1ns / 1ps
`default_nettype none
package tqv_pkg;

  localparam int NUM_ACTIONS = 4;
  localparam int AW          = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
  localparam int TBL         = NUM_ACTIONS * NUM_ACTIONS;
  localparam int TW          = $clog2(TBL);
  localparam int KW          = $clog2(NUM_ACTIONS + 1);

  // queue depth, power of two
  localparam int QDEPTH = 2;
  localparam int QPW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  // datapath widths
  localparam int VW  = 32;  // Q16.16 value
  localparam int P1W = 49;  // gamma * max
  localparam int DW  = 36;  // target - old
  localparam int P2W = 53;  // alpha * diff
  localparam int NVW = 40;  // unsaturated new value

  localparam logic signed [VW-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VW-1:0] Q_MIN = 32'sh8000_0000;

  localparam logic [15:0] ALPHA_RESET = 16'd26214;
  localparam logic [15:0] GAMMA_RESET = 16'd32440;

  localparam int CFG_IW = 2;
  typedef enum logic [CFG_IW-1:0] {
    CFG_LEARNING_RATE = 2'd0,
    CFG_DISCOUNT      = 2'd1
  } cfg_index_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] reward;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] updated_value;
    logic [1:0]         greedy_action;
    logic               saturated;
  } out_rsp_t;

  typedef struct packed {
    logic [AW-1:0]      action;
    logic signed [15:0] reward;
  } q_item_t;

  typedef struct packed {
    logic [15:0] learning_rate;
    logic [15:0] discount;
  } cfg_regs_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL1,
    ST_DIFF,
    ST_MUL2,
    ST_WB,
    ST_FIN
  } back_state_t;

  function automatic logic [AW-1:0] clamp_action(input logic [1:0] a);
    if (int'(a) >= NUM_ACTIONS) begin
      return AW'(NUM_ACTIONS - 1);
    end
    return AW'(a);
  endfunction

  function automatic logic [TW-1:0] tbl_addr(input logic [AW-1:0] row,
                                             input logic [AW-1:0] col);
    return TW'(int'(row) * NUM_ACTIONS + int'(col));
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tabular_q_value_update.sv =====
// Top level of the tabular Q value update block.
//
//   channel  dir  handshake            payload
//   in_      in   in_valid/in_stall    in_req_t  {action, reward}
//   out_     out  out_valid/out_stall  out_rsp_t {updated_value, greedy_action, saturated}
//   cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Steps per request, set by the single Q table port; a queued request goes
//   straight on from the result load, without passing through idle:
//   one read per entry of the next state's row, one read of the old entry,
//   a multiply, a difference, a multiply, a write-back, a result load.
// Reset: rst_n synchronous; Q table valid bits clear at once (no sweep),
//   state goes to 0, alpha 0.8 and gamma 0.99.
// Stalls: a two-entry queue parts front and back; in_stall rises only when
//   it is full. A held result waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
module tabular_q_value_update
  import tqv_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_req_t           in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_rsp_t               out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [15:0]       cfg_data
);

  cfg_regs_t cfg_r;
  q_status_t q_stat;
  q_item_t   push_item;
  q_item_t   pop_item;
  logic      push;
  logic      pop;

  // config writes always taken; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.learning_rate <= ALPHA_RESET;
      cfg_r.discount      <= GAMMA_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LEARNING_RATE: cfg_r.learning_rate <= cfg_data;
        CFG_DISCOUNT:      cfg_r.discount      <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: accept and clamp the action
  tqv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_item (push_item),
    .q_stat    (q_stat)
  );

  // queue between front and back
  tqv_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  // back: table scan, update math, result register
  tqv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_stat    (q_stat),
    .pop_item  (pop_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/tqv_front.sv =====
// Front end: accepts requests, clamps the action and pushes into the queue.
`timescale 1ns / 1ps
`default_nettype none
module tqv_front
  import tqv_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_req_t   in_data,
  output logic           push,
  output q_item_t        push_item,
  input  wire q_status_t q_stat
);

  logic unused_clk;
  assign unused_clk = clk ^ rst_n;

  assign in_stall         = q_stat.full;
  assign push             = in_valid && !q_stat.full;
  assign push_item.action = clamp_action(in_data.action);
  assign push_item.reward = in_data.reward;

endmodule
`default_nettype wire

// ===== rtl/tqv_fifo.sv =====
// Short queue between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module tqv_fifo
  import tqv_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire q_item_t push_item,
  input  wire logic    pop,
  output q_item_t      pop_item,
  output q_status_t    q_stat
);

  q_item_t        ent_r [QDEPTH];
  logic [QPW-1:0] wr_ptr_r;
  logic [QPW-1:0] rd_ptr_r;
  logic [QPW:0]   count_r;

  assign pop_item     = ent_r[rd_ptr_r];
  assign q_stat.full  = (count_r == (QPW+1)'(QDEPTH));
  assign q_stat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tqv_back.sv =====
// Back end: Q table memory, row scan, update arithmetic and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "tabular_q_value_update_assert.svh"
module tqv_back
  import tqv_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_regs_t cfg,
  input  wire q_status_t q_stat,
  input  wire q_item_t   pop_item,
  output logic           pop,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_rsp_t       out_data
);

  back_state_t state_r, state_nxt;

  // Q table with per-entry valid bits; invalid entries read as zero
  logic signed [VW-1:0] mem [TBL];
  logic [TBL-1:0]       vld_r;
  logic signed [VW-1:0] rd_r;

  logic [KW-1:0]        k_r;
  logic [AW-1:0]        cur_s_r;
  logic [AW-1:0]        act_r;
  logic signed [15:0]   rew_r;
  logic signed [VW-1:0] mx_r;
  logic signed [VW-1:0] diag_r;
  logic signed [VW-1:0] bx_v_r;
  logic [AW-1:0]        bx_i_r;
  logic                 bx_ok_r;
  logic signed [VW-1:0] old_r;
  logic signed [P1W-1:0] prod1_r;
  logic signed [DW-1:0]  diff_r;
  logic signed [P2W-1:0] prod2_r;
  logic signed [VW-1:0] stored_r;
  logic                 sat_r;
  logic                 out_valid_r;
  out_rsp_t             out_data_r;

  logic                 rd_en;
  logic [TW-1:0]        rd_addr;
  logic                 we;
  logic [TW-1:0]        wr_addr;
  logic                 out_load;
  logic                 out_free;

  logic [KW-1:0]         k_dec;
  logic [AW-1:0]         rd_col;
  logic signed [P1W-1:0] rnd1;
  logic signed [P2W-1:0] rnd2;
  logic signed [NVW-1:0] nv;
  logic signed [VW-1:0]  stored_nxt;
  logic                  sat_nxt;
  logic signed [VW-1:0]  va;
  logic                  take_a;
  logic [AW-1:0]         g_idx;

  assign out_free  = !out_valid_r || !out_stall;
  assign wr_addr   = tbl_addr(cur_s_r, act_r);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    we        = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        rd_en = 1'b1;
        if (k_r < KW'(NUM_ACTIONS)) begin
          rd_addr = tbl_addr(act_r, k_r[AW-1:0]);
        end else begin
          rd_addr   = tbl_addr(cur_s_r, act_r);
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: state_nxt = ST_DIFF;
      ST_DIFF: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_WB;
      ST_WB: begin
        we        = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          if (!q_stat.empty) begin
            pop       = 1'b1;
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // arithmetic; rounding is floor((p + 2^14) / 2^15)
  always_comb begin
    k_dec      = k_r - 1'b1;
    rd_col     = k_dec[AW-1:0];
    rnd1       = (prod1_r + P1W'(16384)) >>> 15;
    rnd2       = (prod2_r + P2W'(16384)) >>> 15;
    nv         = NVW'(old_r) + NVW'(rnd2);
    sat_nxt    = 1'b0;
    stored_nxt = nv[VW-1:0];
    if (nv > NVW'(Q_MAX)) begin
      stored_nxt = Q_MAX;
      sat_nxt    = 1'b1;
    end else if (nv < NVW'(Q_MIN)) begin
      stored_nxt = Q_MIN;
      sat_nxt    = 1'b1;
    end
    // column of the action after the write, against best of the others
    va     = (cur_s_r == act_r) ? stored_r : diag_r;
    take_a = !bx_ok_r || (va > bx_v_r) || ((va == bx_v_r) && (act_r < bx_i_r));
    g_idx  = take_a ? act_r : bx_i_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      cur_s_r     <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        k_r <= '0;
      end else if (state_r == ST_READ) begin
        k_r <= k_r + 1'b1;
      end
      if (we) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (out_load) begin
        cur_s_r     <= act_r;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // memory port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= stored_nxt;
    end
    if (rd_en) begin
      rd_r <= vld_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (pop) begin
      act_r   <= pop_item.action;
      rew_r   <= pop_item.reward;
      bx_ok_r <= 1'b0;
    end
    if (state_r == ST_READ && k_r != '0) begin
      if (rd_col == '0 || rd_r > mx_r) begin
        mx_r <= rd_r;
      end
      if (rd_col == act_r) begin
        diag_r <= rd_r;
      end else if (!bx_ok_r || rd_r > bx_v_r) begin
        bx_v_r  <= rd_r;
        bx_i_r  <= rd_col;
        bx_ok_r <= 1'b1;
      end
    end
    if (state_r == ST_MUL1) begin
      old_r   <= rd_r;
      prod1_r <= P1W'($signed({1'b0, cfg.discount})) * P1W'(mx_r);
    end
    if (state_r == ST_DIFF) begin
      diff_r <= DW'($signed({rew_r, 8'h00})) + DW'(rnd1) - DW'(old_r);
    end
    if (state_r == ST_MUL2) begin
      prod2_r <= P2W'($signed({1'b0, cfg.learning_rate})) * P2W'(diff_r);
    end
    if (state_r == ST_WB) begin
      stored_r <= stored_nxt;
      sat_r    <= sat_nxt;
    end
    if (out_load) begin
      out_data_r.updated_value <= stored_r;
      out_data_r.greedy_action <= 2'(g_idx);
      out_data_r.saturated     <= sat_r;
    end
  end

  `TQV_ASSERT_NOW(a_read_after_pop, state_r == ST_READ && k_r == '0, $past(pop), "scan without pop")
  `TQV_ASSERT_NOW(a_scan_len, state_r == ST_MUL1, $past(k_r) == KW'(NUM_ACTIONS), "short scan")
  `TQV_ASSERT_NEXT(a_wb_marks, state_r == ST_WB, state_r == ST_FIN && vld_r[wr_addr], "lost write")
  `TQV_ASSERT_NOW(a_out_from_fin, $rose(out_valid_r), $past(state_r) == ST_FIN, "stray result")

endmodule
`default_nettype wire
